// ===== rtl/bmhq_pkg.sv =====
// Shared constants, types and command/status structures for the binary min-heap queue.
`timescale 1ns / 1ps
`default_nettype none
package bmhq_pkg;

  // Heap geometry
  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int EXT_W    = ADDR_W + 2;

  // Field widths fixed by the transaction format
  localparam int IDX_W    = 16;
  localparam int KEY_W    = 16;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = IDX_W + KEY_W;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED = 2'd0,
    ST_FULL   = 2'd1,
    ST_POPPED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RD_ROOT   = 3'd0,
    RD_PARENT = 3'd1,
    RD_LAST   = 3'd2,
    RD_LC     = 3'd3,
    RD_RC     = 3'd4
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_MOV   = 2'd0,
    WR_RDATA = 2'd1,
    WR_LC    = 2'd2
  } wr_sel_t;

  typedef enum logic [2:0] {
    POS_HOLD   = 3'd0,
    POS_COUNT  = 3'd1,
    POS_ZERO   = 3'd2,
    POS_PARENT = 3'd3,
    POS_LC     = 3'd4,
    POS_RC     = 3'd5
  } pos_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     ld_req;
    logic     clr_popped;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wr_sel_t  wr_sel;
    pos_sel_t pos_sel;
    logic     ld_popped;
    logic     ld_mov;
    logic     ld_lc;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     set_code;
    status_t  code;
    logic     ld_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic cnt_one;
    logic pos_zero;
    logic lc_in;
    logic rc_in;
    logic mov_lt_rd;
    logic rd_lt_best;
    logic lc_win;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/bmhq_req_if.sv =====
// Request channel interface: valid/ready handshake with push/pop payload.
`timescale 1ns / 1ps
`default_nettype none
interface bmhq_req_if;
  import bmhq_pkg::*;

  logic             valid;
  logic             ready;
  logic             req_type;
  logic [IDX_W-1:0] item_index;
  logic [KEY_W-1:0] priority_req;

  modport source (output valid, output req_type, output item_index, output priority_req,
                  input ready);
  modport sink   (input valid, input req_type, input item_index, input priority_req,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/bmhq_rsp_if.sv =====
// Result channel interface: valid/ready handshake with status and count payload.
`timescale 1ns / 1ps
`default_nettype none
interface bmhq_rsp_if;
  import bmhq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    popped_index;
  logic [CNT_W-1:0]    entry_count;
  logic                is_empty;

  modport source (output valid, output status, output popped_index, output entry_count,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input popped_index, input entry_count,
                  input is_empty, output ready);
endinterface
`default_nettype wire

// ===== rtl/binary_min_heap_queue_top.sv =====
// Top level of the binary min-heap priority queue: controller, datapath and channel wiring.
//
// Usage: each request transaction on in_ch either pushes an (item_index, priority_req)
// pair (req_type 0) or pops the entry with the smallest priority (req_type 1). Every
// request yields exactly one result transaction on out_ch carrying the status code,
// the popped payload (zero unless a pop succeeded), the entry count after the request
// and an empty flag. Equal priorities are served in heap order, not strictly FIFO.
// Requests are handled one at a time; in_ch.ready is high only while the controller
// is idle. A push climbs the heap level by level (one read of the parent, then
// one compare-and-write). A pop reads the root and the last entry, then descends
// level by level (left child read, right child read, compare-and-write). At 1024
// entries a push climbs at most ten levels and a pop descends at most nine, as the
// last entry has left the bottom row; the entry store has a single read port, so
// the reads of each level are made one after the other. A dropped push or an empty
// pop goes straight to the result. The result sits in an output register: the next
// request is accepted while it waits, and only the completion of that next request
// waits for out_ch.ready. Reset (rst_n low, synchronous) empties the heap and drops
// any pending result; the entry store itself is not cleared, as only entries below
// the count are ever read.
`timescale 1ns / 1ps
`default_nettype none
module binary_min_heap_queue_top (
  input  logic    clk,
  input  logic    rst_n,
  bmhq_req_if.sink   in_ch,
  bmhq_rsp_if.source out_ch
);
  import bmhq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  bmhq_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_item_index    (in_ch.item_index),
    .in_priority_req  (in_ch.priority_req),
    .out_status       (out_ch.status),
    .out_popped_index (out_ch.popped_index),
    .out_entry_count  (out_ch.entry_count),
    .out_is_empty     (out_ch.is_empty)
  );

  // Once a request transaction is taken, in_ch.ready is low in the cycle after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while the previous one was still in progress");

  // A new result must never overwrite one that has not yet been taken.
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> (!out_ch.valid || out_ch.ready))
    else $error("result register reloaded while a result was still pending");

  // The store has one write port and one read port; it is never read and written in the same cycle.
  a_no_read_write_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_en && cmd.rd_en))
    else $error("entry store read and written in the same cycle");

  // The empty flag must agree with the reported count.
  a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.is_empty == (out_ch.entry_count == '0)))
    else $error("empty flag disagrees with entry count");

endmodule
`default_nettype wire

// ===== rtl/bmhq_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bmhq_datapath.sv =====
// Heap datapath: entry store, position and count registers, key comparators, result registers.
`timescale 1ns / 1ps
`default_nettype none
module bmhq_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bmhq_pkg::cmd_t                   cmd,
  output bmhq_pkg::sts_t                   sts,
  input  logic [bmhq_pkg::IDX_W-1:0]       in_item_index,
  input  logic [bmhq_pkg::KEY_W-1:0]       in_priority_req,
  output logic [bmhq_pkg::STATUS_W-1:0]    out_status,
  output logic [bmhq_pkg::IDX_W-1:0]       out_popped_index,
  output logic [bmhq_pkg::CNT_W-1:0]       out_entry_count,
  output logic                             out_is_empty
);
  import bmhq_pkg::*;

  logic [CNT_W-1:0]  count_r;
  logic [ADDR_W-1:0] pos_r;
  entry_t            mov_r;
  entry_t            lc_r;
  logic              lc_win_r;
  logic [IDX_W-1:0]  popped_r;
  status_t           code_r;

  logic [STATUS_W-1:0] res_status_r;
  logic [IDX_W-1:0]    res_popped_r;
  logic [CNT_W-1:0]    res_count_r;
  logic                res_empty_r;

  logic [EXT_W-1:0]  lc_ext;
  logic [EXT_W-1:0]  rc_ext;
  logic [EXT_W-1:0]  cnt_ext;
  logic [ADDR_W-1:0] pos_m1;
  logic [ADDR_W-1:0] parent_addr;
  logic [ADDR_W-1:0] lc_addr;
  logic [ADDR_W-1:0] rc_addr;
  logic [ADDR_W-1:0] last_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [KEY_W-1:0]  best_key;
  logic [ENTRY_W-1:0] rd_raw;
  logic [ENTRY_W-1:0] wr_data;
  entry_t            rdata;

  // Child positions are formed one bit wider than the count so the bound check cannot wrap.
  assign lc_ext      = {1'b0, pos_r, 1'b1};
  assign rc_ext      = lc_ext + EXT_W'(1);
  assign cnt_ext     = EXT_W'(count_r);
  assign lc_addr     = lc_ext[ADDR_W-1:0];
  assign rc_addr     = rc_ext[ADDR_W-1:0];
  assign pos_m1      = pos_r - ADDR_W'(1);
  assign parent_addr = pos_m1 >> 1;
  assign last_addr   = ADDR_W'(count_r - CNT_W'(1));
  assign rdata       = entry_t'(rd_raw);
  assign best_key    = lc_win_r ? lc_r.key : mov_r.key;

  always_comb begin
    case (cmd.rd_sel)
      RD_ROOT:   rd_addr = '0;
      RD_PARENT: rd_addr = parent_addr;
      RD_LAST:   rd_addr = last_addr;
      RD_LC:     rd_addr = lc_addr;
      RD_RC:     rd_addr = rc_addr;
      default:   rd_addr = '0;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_MOV:   wr_data = mov_r;
      WR_RDATA: wr_data = rdata;
      WR_LC:    wr_data = lc_r;
      default:  wr_data = mov_r;
    endcase
  end

  bmhq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (pos_r),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.pos_sel)
      POS_HOLD:   pos_r <= pos_r;
      POS_COUNT:  pos_r <= ADDR_W'(count_r);
      POS_ZERO:   pos_r <= '0;
      POS_PARENT: pos_r <= parent_addr;
      POS_LC:     pos_r <= lc_addr;
      POS_RC:     pos_r <= rc_addr;
      default:    pos_r <= pos_r;
    endcase
    if (cmd.ld_req) begin
      mov_r.idx <= in_item_index;
      mov_r.key <= in_priority_req;
    end else if (cmd.ld_mov) begin
      mov_r <= rdata;
    end
    if (cmd.ld_lc) begin
      lc_r     <= rdata;
      lc_win_r <= rdata.key < mov_r.key;
    end
    if (cmd.clr_popped) begin
      popped_r <= '0;
    end else if (cmd.ld_popped) begin
      popped_r <= rdata.idx;
    end
    if (cmd.set_code) begin
      code_r <= cmd.code;
    end
    if (cmd.ld_out) begin
      res_status_r <= code_r;
      res_popped_r <= popped_r;
      res_count_r  <= count_r;
      res_empty_r  <= (count_r == '0);
    end
  end

  always_comb begin
    sts.full       = (count_r == CNT_W'(CAPACITY));
    sts.empty      = (count_r == '0);
    sts.cnt_one    = (count_r == CNT_W'(1));
    sts.pos_zero   = (pos_r == '0);
    sts.lc_in      = (lc_ext < cnt_ext);
    sts.rc_in      = (rc_ext < cnt_ext);
    sts.mov_lt_rd  = (mov_r.key < rdata.key);
    sts.rd_lt_best = (rdata.key < best_key);
    sts.lc_win     = lc_win_r;
  end

  assign out_status       = res_status_r;
  assign out_popped_index = res_popped_r;
  assign out_entry_count  = res_count_r;
  assign out_is_empty     = res_empty_r;

endmodule
`default_nettype wire

// ===== rtl/bmhq_ctrl.sv =====
// Heap controller: sequences sift-up and sift-down steps and the result handshake.
`timescale 1ns / 1ps
`default_nettype none
module bmhq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_req_type,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  bmhq_pkg::sts_t sts,
  output bmhq_pkg::cmd_t cmd
);
  import bmhq_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_UP_CHK  = 10'b0000000010,
    S_UP_CMP  = 10'b0000000100,
    S_DN_ROOT = 10'b0000001000,
    S_DN_LAST = 10'b0000010000,
    S_DN_CHK  = 10'b0000100000,
    S_DN_LC   = 10'b0001000000,
    S_DN_RC   = 10'b0010000000,
    S_DN_LEAF = 10'b0100000000,
    S_FIN     = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.clr_popped = 1'b1;
          if (in_req_type == REQ_PUSH) begin
            if (sts.full) begin
              cmd.set_code = 1'b1;
              cmd.code     = ST_FULL;
              state_nxt    = S_FIN;
            end else begin
              cmd.ld_req  = 1'b1;
              cmd.pos_sel = POS_COUNT;
              state_nxt   = S_UP_CHK;
            end
          end else begin
            if (sts.empty) begin
              cmd.set_code = 1'b1;
              cmd.code     = ST_EMPTY;
              state_nxt    = S_FIN;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_ROOT;
              state_nxt  = S_DN_ROOT;
            end
          end
        end
      end
      S_UP_CHK: begin
        if (sts.pos_zero) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_sel   = WR_MOV;
          cmd.cnt_inc  = 1'b1;
          cmd.set_code = 1'b1;
          cmd.code     = ST_PUSHED;
          state_nxt    = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PARENT;
          state_nxt  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.wr_en = 1'b1;
        if (sts.mov_lt_rd) begin
          cmd.wr_sel  = WR_RDATA;
          cmd.pos_sel = POS_PARENT;
          state_nxt   = S_UP_CHK;
        end else begin
          cmd.wr_sel   = WR_MOV;
          cmd.cnt_inc  = 1'b1;
          cmd.set_code = 1'b1;
          cmd.code     = ST_PUSHED;
          state_nxt    = S_FIN;
        end
      end
      S_DN_ROOT: begin
        cmd.ld_popped = 1'b1;
        cmd.cnt_dec   = 1'b1;
        cmd.set_code  = 1'b1;
        cmd.code      = ST_POPPED;
        if (sts.cnt_one) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LAST;
          state_nxt  = S_DN_LAST;
        end
      end
      S_DN_LAST: begin
        cmd.ld_mov  = 1'b1;
        cmd.pos_sel = POS_ZERO;
        state_nxt   = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (sts.lc_in) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LC;
          state_nxt  = S_DN_LC;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_MOV;
          state_nxt  = S_FIN;
        end
      end
      S_DN_LC: begin
        cmd.ld_lc = 1'b1;
        if (sts.rc_in) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_RC;
          state_nxt  = S_DN_RC;
        end else begin
          state_nxt = S_DN_LEAF;
        end
      end
      S_DN_RC: begin
        cmd.wr_en = 1'b1;
        if (sts.rd_lt_best) begin
          cmd.wr_sel  = WR_RDATA;
          cmd.pos_sel = POS_RC;
          state_nxt   = S_DN_CHK;
        end else if (sts.lc_win) begin
          cmd.wr_sel  = WR_LC;
          cmd.pos_sel = POS_LC;
          state_nxt   = S_DN_CHK;
        end else begin
          cmd.wr_sel = WR_MOV;
          state_nxt  = S_FIN;
        end
      end
      S_DN_LEAF: begin
        cmd.wr_en = 1'b1;
        if (sts.lc_win) begin
          cmd.wr_sel  = WR_LC;
          cmd.pos_sel = POS_LC;
          state_nxt   = S_DN_CHK;
        end else begin
          cmd.wr_sel = WR_MOV;
          state_nxt  = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire
